>>> design/ilbm_pkg.sv
// ----------------------------------------------------------------------------
// ilbm_pkg
// Shared types, constants, microcode table and IEC scale function for the
// level bar meter.
// ----------------------------------------------------------------------------
package ilbm_pkg;

    localparam int DB_W    = 12;             // dB fields, 1/16 dB, signed
    localparam int DEFL_W  = 15;             // deflection, 1/64 percent
    localparam int LEN_W   = 10;             // bar lengths
    localparam int DEN_W   = DEFL_W + 1;     // signed deflection difference
    localparam int NUM_W   = DEFL_W + 2;     // signed divider numerator
    localparam int PROD_W  = DEFL_W + LEN_W; // numerator times bar length
    localparam int CNT_W   = $clog2(LEN_W);
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int STEP_W  = 4;

    localparam logic [DEFL_W-1:0] FULL_SCALE = 15'd6400;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_FLOOR   = 3'd0;
    localparam logic [2:0] REG_CEILING = 3'd1;
    localparam logic [2:0] REG_WARN    = 3'd2;
    localparam logic [2:0] REG_REVERSE = 3'd3;
    localparam logic [2:0] REG_BAR     = 3'd4;

    typedef logic [STEP_W-1:0] step_t;

    // Microprogram step addresses
    localparam step_t ST_WAIT = 4'd0;
    localparam step_t ST_LO   = 4'd1;
    localparam step_t ST_UP   = 4'd2;
    localparam step_t ST_W    = 4'd3;
    localparam step_t ST_NA   = 4'd4;
    localparam step_t ST_DNV  = 4'd5;
    localparam step_t ST_QR   = 4'd6;
    localparam step_t ST_DNA  = 4'd7;
    localparam step_t ST_QG   = 4'd8;
    localparam step_t ST_DFS  = 4'd9;
    localparam step_t ST_QA   = 4'd10;
    localparam step_t ST_DPK  = 4'd11;
    localparam step_t ST_QP   = 4'd12;
    localparam step_t ST_EMIT = 4'd13;

    typedef enum logic [1:0] {DSRC_LEVEL, DSRC_FLOOR, DSRC_CEIL, DSRC_WARN} defl_src_t;
    typedef enum logic [2:0] {DDST_NONE, DDST_V, DDST_LO, DDST_UP, DDST_W} defl_dst_t;
    typedef enum logic [1:0] {OPND_NV, OPND_NA, OPND_FS, OPND_PK} opnd_t;
    typedef enum logic [2:0] {QDST_NONE, QDST_R, QDST_G, QDST_A, QDST_P} qdst_t;
    typedef enum logic [2:0] {
        JC_ALWAYS, JC_NO_ACCEPT, JC_CLEAR_OP, JC_DIV_BUSY, JC_OUT_FULL
    } jcond_t;

    typedef struct packed {
        defl_src_t defl_src;
        defl_dst_t defl_dst;
        logic      upd_peak;
        logic      ld_na;
        logic      div_start;
        opnd_t     opnd;
        qdst_t     qdst;
        logic      emit;
        jcond_t    cond;
        step_t     jt;     // taken when cond holds
        step_t     jn;     // taken otherwise
    } ucode_t;

    typedef enum logic [1:0] {DIV_IDLE, DIV_MUL, DIV_RUN} div_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
    } div_req_t;

    // Control store: one word per step.
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t u;
        u      = '0;
        u.cond = JC_ALWAYS;
        u.jt   = ST_WAIT;
        u.jn   = ST_WAIT;
        case (s)
            ST_WAIT: begin
                u.defl_src = DSRC_LEVEL;
                u.defl_dst = DDST_V;
                u.cond     = JC_NO_ACCEPT;
                u.jt       = ST_WAIT;
                u.jn       = ST_LO;
            end
            ST_LO: begin
                u.defl_src = DSRC_FLOOR;
                u.defl_dst = DDST_LO;
                u.cond     = JC_CLEAR_OP;
                u.jt       = ST_EMIT;
                u.jn       = ST_UP;
            end
            ST_UP: begin
                u.defl_src = DSRC_CEIL;
                u.defl_dst = DDST_UP;
                u.jt       = ST_W;
            end
            ST_W: begin
                u.defl_src = DSRC_WARN;
                u.defl_dst = DDST_W;
                u.upd_peak = 1'b1;
                u.jt       = ST_NA;
            end
            ST_NA: begin
                u.ld_na = 1'b1;
                u.jt    = ST_DNV;
            end
            ST_DNV: begin
                u.div_start = 1'b1;
                u.opnd      = OPND_NV;
                u.jt        = ST_QR;
            end
            ST_QR: begin
                u.qdst = QDST_R;
                u.cond = JC_DIV_BUSY;
                u.jt   = ST_QR;
                u.jn   = ST_DNA;
            end
            ST_DNA: begin
                u.div_start = 1'b1;
                u.opnd      = OPND_NA;
                u.jt        = ST_QG;
            end
            ST_QG: begin
                u.qdst = QDST_G;
                u.cond = JC_DIV_BUSY;
                u.jt   = ST_QG;
                u.jn   = ST_DFS;
            end
            ST_DFS: begin
                u.div_start = 1'b1;
                u.opnd      = OPND_FS;
                u.jt        = ST_QA;
            end
            ST_QA: begin
                u.qdst = QDST_A;
                u.cond = JC_DIV_BUSY;
                u.jt   = ST_QA;
                u.jn   = ST_DPK;
            end
            ST_DPK: begin
                u.div_start = 1'b1;
                u.opnd      = OPND_PK;
                u.jt        = ST_QP;
            end
            ST_QP: begin
                u.qdst = QDST_P;
                u.cond = JC_DIV_BUSY;
                u.jt   = ST_QP;
                u.jn   = ST_EMIT;
            end
            ST_EMIT: begin
                u.emit = 1'b1;
                u.cond = JC_OUT_FULL;
                u.jt   = ST_EMIT;
                u.jn   = ST_WAIT;
            end
            default: begin
                u.jt = ST_WAIT;
            end
        endcase
        return u;
    endfunction

    // Seven-piece IEC scale: 1/16 dB in, 1/64 percent out, exact.
    function automatic logic [DEFL_W-1:0] iec_defl(input logic signed [DB_W-1:0] d);
        logic signed [DEN_W-1:0] x;
        logic signed [DEN_W-1:0] y;
        x = DEN_W'(d);
        if (x < -1120)
            y = '0;
        else if (x < -960)
            y = DEN_W'(x + 1120);
        else if (x < -800)
            y = DEN_W'((x + 960) * 2 + 320);
        else if (x < -640)
            y = DEN_W'((x + 800) * 3 + 480);
        else if (x < -480)
            y = DEN_W'((x + 640) * 6 + 960);
        else if (x < -320)
            y = DEN_W'((x + 480) * 8 + 1920);
        else
            y = DEN_W'((x + 320) * 10 + 3200);
        return y[DEFL_W-1:0];
    endfunction

endpackage

>>> design/ilbm_div.sv
// ----------------------------------------------------------------------------
// ilbm_div
// Bar length unit: trunc(num * len / den), zero for num <= 0 or den <= 0,
// saturated at len. A multiply step, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ilbm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ilbm_pkg::div_req_t            req,
    input  logic [ilbm_pkg::LEN_W-1:0]    len,
    output logic                          busy,
    output logic [ilbm_pkg::LEN_W-1:0]    quo
);
    import ilbm_pkg::*;

    div_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DEFL_W-1:0]   num_reg, num_next;
    logic [DEFL_W-1:0]   den_reg, den_next;
    logic [DEFL_W-1:0]   rem_reg, rem_next;
    logic [LEN_W-1:0]    low_reg, low_next;
    logic [PROD_W-1:0]   prod;
    logic [DEFL_W:0]     trial;
    logic                trivial_zero;
    logic                saturate;

    assign trivial_zero = ($signed(req.num) <= 0) || ($signed(req.den) <= 0);
    assign saturate     = $signed(req.num) >= $signed(NUM_W'($signed(req.den)));
    assign prod         = PROD_W'(num_reg) * PROD_W'(len);
    assign trial        = {rem_reg, low_reg[LEN_W-1]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (req.start && !trivial_zero && !saturate)
                    state_next = DIV_MUL;
            end
            DIV_MUL:
                state_next = DIV_RUN;
            DIV_RUN:
            begin
                if (cnt_reg == CNT_W'(LEN_W - 1))
                    state_next = DIV_IDLE;
            end
            default:
                state_next = DIV_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != DIV_IDLE);
        quo  = low_reg;
    end

    // datapath
    always_comb
    begin
        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        low_next = low_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    if (trivial_zero)
                        low_next = '0;
                    else if (saturate)
                        low_next = len;
                    else
                    begin
                        num_next = req.num[DEFL_W-1:0];
                        den_next = req.den[DEFL_W-1:0];
                    end
                end
            end
            DIV_MUL:
            begin
                // upper part is already below den since num < den
                rem_next = prod[PROD_W-1:LEN_W];
                low_next = prod[LEN_W-1:0];
                cnt_next = '0;
            end
            DIV_RUN:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = DEFL_W'(trial - {1'b0, den_reg});
                    low_next = {low_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DEFL_W-1:0];
                    low_next = {low_reg[LEN_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DIV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

endmodule

>>> design/iec_level_bar_meter.sv
// ----------------------------------------------------------------------------
// iec_level_bar_meter
// Level meter on the IEC peak meter scale with held peak and bar segments.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid/sample_stall, opcode, level_db) carries one
//   request per level sample or peak clear. Meter channel (meter_valid/
//   meter_stall) returns one result per request: green/amber/red bar ends,
//   the peak mark position, peak_shown and the sample's IEC deflection.
//   Registers sit on an APB-style port at byte addresses 0,4,8,12,16:
//   floor_db, ceiling_db, warn_db, reverse_warn, bar_length. Write them only
//   while no request is in flight.
//   Division: a level sample runs the shared bar length divider four times;
//   a clear skips it. The divider retires one quotient bit per cycle after
//   a multiply step; divisions with a trivial answer finish at once.
//   A microcoded sequencer steps through the work; sample_stall is low only
//   on its wait step. The next request is taken while a finished result still
//   sits in the output register; the sequencer holds at its emit step only
//   when that register is full and stalled.
//   Reset: registers take their default values, held peak clears, both
//   channels go idle.
// ----------------------------------------------------------------------------
module iec_level_bar_meter #(
    parameter int MAX_BAR_LENGTH = 1023
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ilbm_pkg::ADDR_W-1:0]         paddr,
    input  logic [ilbm_pkg::DATA_W-1:0]         pwdata,
    output logic [ilbm_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic                                opcode,
    input  logic signed [ilbm_pkg::DB_W-1:0]    level_db,
    output logic                                meter_valid,
    input  logic                                meter_stall,
    output logic [ilbm_pkg::LEN_W-1:0]          green_end,
    output logic [ilbm_pkg::LEN_W-1:0]          amber_end,
    output logic [ilbm_pkg::LEN_W-1:0]          red_end,
    output logic [ilbm_pkg::LEN_W-1:0]          peak_pos,
    output logic                                peak_shown,
    output logic [ilbm_pkg::DEFL_W-1:0]         deflection
);
    import ilbm_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [DB_W-1:0] floor_reg, floor_next;
    logic signed [DB_W-1:0] ceiling_reg, ceiling_next;
    logic signed [DB_W-1:0] warn_reg, warn_next;
    logic                   reverse_reg, reverse_next;
    logic [LEN_W-1:0]       bar_reg, bar_next;
    logic                   cfg_wr;
    logic [2:0]             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        floor_next   = floor_reg;
        ceiling_next = ceiling_reg;
        warn_next    = warn_reg;
        reverse_next = reverse_reg;
        bar_next     = bar_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FLOOR:   floor_next   = pwdata[DB_W-1:0];
                REG_CEILING: ceiling_next = pwdata[DB_W-1:0];
                REG_WARN:    warn_next    = pwdata[DB_W-1:0];
                REG_REVERSE: reverse_next = pwdata[0];
                REG_BAR:     bar_next     = pwdata[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FLOOR:   prdata = DATA_W'(floor_reg);
            REG_CEILING: prdata = DATA_W'(ceiling_reg);
            REG_WARN:    prdata = DATA_W'(warn_reg);
            REG_REVERSE: prdata = DATA_W'(reverse_reg);
            REG_BAR:     prdata = DATA_W'(bar_reg);
            default:     prdata = '0;
        endcase
    end

    // bar length saturated at the build limit
    logic [LEN_W-1:0] len_eff;
    assign len_eff = (int'(bar_reg) > MAX_BAR_LENGTH) ? LEN_W'(MAX_BAR_LENGTH) : bar_reg;

    // ---------------- sequencer ----------------
    step_t  upc_reg, upc_next;
    ucode_t uc;
    logic   cond_hit;
    logic   sample_take;
    logic   meter_take;
    logic   out_full;
    logic   div_busy;
    logic   emit_go;
    logic   op_reg, op_next;

    assign uc           = ucode_rom(upc_reg);
    assign sample_stall = (upc_reg != ST_WAIT);
    assign sample_take  = sample_valid && !sample_stall;
    assign meter_take   = meter_valid && !meter_stall;
    assign out_full     = meter_valid && meter_stall;
    assign emit_go      = uc.emit && !out_full;

    always_comb
    begin
        case (uc.cond)
            JC_ALWAYS:    cond_hit = 1'b1;
            JC_NO_ACCEPT: cond_hit = !sample_take;
            JC_CLEAR_OP:  cond_hit = op_reg;
            JC_DIV_BUSY:  cond_hit = div_busy;
            JC_OUT_FULL:  cond_hit = out_full;
            default:      cond_hit = 1'b1;
        endcase
        upc_next = cond_hit ? uc.jt : uc.jn;
    end

    // ---------------- datapath ----------------
    logic [DEFL_W-1:0]       v_reg, v_next;      // sample deflection
    logic [DEFL_W-1:0]       lo_reg, lo_next;    // floor deflection
    logic [DEFL_W-1:0]       up_reg, up_next;    // ceiling deflection
    logic [DEFL_W-1:0]       w_reg, w_next;      // warn deflection
    logic signed [NUM_W-1:0] na_reg, na_next;    // amber point above floor
    logic [DEFL_W-1:0]       held_reg, held_next;
    logic [LEN_W-1:0]        qr_reg, qr_next;
    logic [LEN_W-1:0]        qg_reg, qg_next;
    logic [LEN_W-1:0]        qa_reg, qa_next;
    logic [LEN_W-1:0]        qp_reg, qp_next;

    logic signed [DB_W-1:0]  defl_in;
    logic [DEFL_W-1:0]       defl_out;
    logic signed [DEN_W-1:0] den;
    logic signed [DEN_W-1:0] nv;
    logic signed [DEN_W-1:0] wl;
    logic signed [DEN_W-1:0] fs_lo;
    logic signed [DEN_W-1:0] pk_lo;
    div_req_t                div_req;
    logic [LEN_W-1:0]        div_quo;
    logic                    q_wr;

    // shared scale unit
    always_comb
    begin
        case (uc.defl_src)
            DSRC_LEVEL: defl_in = level_db;
            DSRC_FLOOR: defl_in = floor_reg;
            DSRC_CEIL:  defl_in = ceiling_reg;
            DSRC_WARN:  defl_in = warn_reg;
            default:    defl_in = level_db;
        endcase
        defl_out = iec_defl(defl_in);
    end

    assign den   = $signed({1'b0, up_reg}) - $signed({1'b0, lo_reg});
    assign nv    = $signed({1'b0, v_reg}) - $signed({1'b0, lo_reg});
    assign wl    = $signed({1'b0, w_reg}) - $signed({1'b0, lo_reg});
    assign fs_lo = $signed({1'b0, FULL_SCALE}) - $signed({1'b0, lo_reg});
    assign pk_lo = $signed({1'b0, held_reg}) - $signed({1'b0, lo_reg});

    always_comb
    begin
        div_req.start = uc.div_start;
        div_req.den   = den;
        case (uc.opnd)
            OPND_NV: div_req.num = NUM_W'(nv);
            OPND_NA: div_req.num = na_reg;
            OPND_FS: div_req.num = NUM_W'(fs_lo);
            OPND_PK: div_req.num = NUM_W'(pk_lo);
            default: div_req.num = NUM_W'(nv);
        endcase
    end

    ilbm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .len   (len_eff),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // quotient lands when the wait step sees the divider idle
    assign q_wr = (uc.qdst != QDST_NONE) && !div_busy;

    always_comb
    begin
        v_next    = v_reg;
        lo_next   = lo_reg;
        up_next   = up_reg;
        w_next    = w_reg;
        na_next   = na_reg;
        held_next = held_reg;
        op_next   = op_reg;
        qr_next   = qr_reg;
        qg_next   = qg_reg;
        qa_next   = qa_reg;
        qp_next   = qp_reg;

        case (uc.defl_dst)
            DDST_V:
            begin
                // latch the request only on accept
                if (sample_take)
                begin
                    v_next  = defl_out;
                    op_next = opcode;
                end
            end
            DDST_LO: lo_next = defl_out;
            DDST_UP: up_next = defl_out;
            DDST_W:  w_next  = defl_out;
            default: ;
        endcase

        // peak rises to the sample, capped at the current ceiling
        if (uc.upd_peak && (v_reg > held_reg))
            held_next = (v_reg > up_reg) ? up_reg : v_reg;

        if (uc.ld_na)
            na_next = reverse_reg ? (NUM_W'(den) - NUM_W'(wl)) : NUM_W'(wl);

        if (q_wr)
        begin
            case (uc.qdst)
                QDST_R:  qr_next = div_quo;
                QDST_G:  qg_next = div_quo;
                QDST_A:  qa_next = div_quo;
                QDST_P:  qp_next = div_quo;
                default: ;
            endcase
        end

        // clear request drops the held peak when its result goes out
        if (emit_go && op_reg)
            held_next = '0;
    end

    // ---------------- result register ----------------
    logic               out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]   green_reg, green_next;
    logic [LEN_W-1:0]   amber_reg, amber_next;
    logic [LEN_W-1:0]   red_reg, red_next;
    logic [LEN_W-1:0]   ppos_reg, ppos_next;
    logic               shown_reg, shown_next;
    logic [DEFL_W-1:0]  defl_reg, defl_next;
    logic               below_amber;
    logic               in_scale;
    logic               pk_above;

    assign below_amber = $signed(NUM_W'(nv)) < na_reg;
    assign in_scale    = (v_reg <= FULL_SCALE);
    assign pk_above    = (pk_lo > 0);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        green_next     = green_reg;
        amber_next     = amber_reg;
        red_next       = red_reg;
        ppos_next      = ppos_reg;
        shown_next     = shown_reg;
        defl_next      = defl_reg;

        if (meter_take)
            out_valid_next = 1'b0;

        if (emit_go)
        begin
            out_valid_next = 1'b1;
            green_next     = '0;
            amber_next     = '0;
            red_next       = '0;
            ppos_next      = '0;
            shown_next     = 1'b0;
            defl_next      = '0;
            if (!op_reg)
            begin
                defl_next = v_reg;
                // empty scale leaves every bar at zero
                if (den > 0)
                begin
                    red_next = qr_reg;
                    if (below_amber)
                    begin
                        green_next = qr_reg;
                        amber_next = qr_reg;
                    end
                    else if (in_scale)
                    begin
                        green_next = qg_reg;
                        amber_next = qr_reg;
                    end
                    else
                    begin
                        green_next = qg_reg;
                        amber_next = qa_reg;
                    end
                    shown_next = pk_above;
                    ppos_next  = pk_above ? qp_reg : '0;
                end
            end
        end
    end

    assign meter_valid = out_valid_reg;
    assign green_end   = green_reg;
    assign amber_end   = amber_reg;
    assign red_end     = red_reg;
    assign peak_pos    = ppos_reg;
    assign peak_shown  = shown_reg;
    assign deflection  = defl_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg     <= -12'sd960;
            ceiling_reg   <= 12'sd96;
            warn_reg      <= -12'sd96;
            reverse_reg   <= 1'b0;
            bar_reg       <= 10'd100;
            upc_reg       <= ST_WAIT;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            floor_reg     <= floor_next;
            ceiling_reg   <= ceiling_next;
            warn_reg      <= warn_next;
            reverse_reg   <= reverse_next;
            bar_reg       <= bar_next;
            upc_reg       <= upc_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        v_reg     <= v_next;
        lo_reg    <= lo_next;
        up_reg    <= up_next;
        w_reg     <= w_next;
        na_reg    <= na_next;
        qr_reg    <= qr_next;
        qg_reg    <= qg_next;
        qa_reg    <= qa_next;
        qp_reg    <= qp_next;
        green_reg <= green_next;
        amber_reg <= amber_next;
        red_reg   <= red_next;
        ppos_reg  <= ppos_next;
        shown_reg <= shown_next;
        defl_reg  <= defl_next;
    end

    // ---------------- assertions ----------------
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        uc.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_amber_le_red: assert property (@(posedge clk) disable iff (!rst_n)
        meter_valid |-> (amber_end <= red_end))
        else $error("amber end beyond red end");

    a_red_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        meter_valid |-> (red_end <= len_eff))
        else $error("red end beyond bar length");

    a_peak_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        (meter_valid && !peak_shown) |-> (peak_pos == '0))
        else $error("peak mark placed while hidden");

endmodule

>>> bench/tb_iec_level_bar_meter.sv
// ----------------------------------------------------------------------------
// tb_iec_level_bar_meter
// Self-checking bench for the IEC level bar meter: a directed table of level
// samples and peak clears under the reset settings, then random requests over
// a series of register settings, each result checked against its typed value
// or an in-bench model of the scale, held peak and bar segment arithmetic.
// ----------------------------------------------------------------------------
module tb_iec_level_bar_meter;

    timeunit 1ns;
    timeprecision 1ps;

    import ilbm_pkg::*;

    localparam int BAR_MAX       = 1023;   // block's MAX_BAR_LENGTH default
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 135;
    localparam int SETTLE_CYCLES = 64;     // beyond the worst sample latency

    // One result as the block presents it on the meter channel.
    typedef struct packed {
        logic [LEN_W-1:0]  green;
        logic [LEN_W-1:0]  amber;
        logic [LEN_W-1:0]  red;
        logic [LEN_W-1:0]  peak;
        logic              shown;
        logic [DEFL_W-1:0] defl;
    } meter_t;

    // One row of the directed table; typed rows carry a hand-worked result.
    typedef struct packed {
        logic             clr;
        logic [DB_W-1:0]  lvl;
        logic             typed;
        meter_t           want;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     sample_valid;
    logic                     sample_stall;
    logic                     opcode;
    logic signed [DB_W-1:0]   level_db;
    logic                     meter_valid;
    logic                     meter_stall;
    logic [LEN_W-1:0]         green_end;
    logic [LEN_W-1:0]         amber_end;
    logic [LEN_W-1:0]         red_end;
    logic [LEN_W-1:0]         peak_pos;
    logic                     peak_shown;
    logic [DEFL_W-1:0]        deflection;

    // Register copies and held peak as the bench believes them to be.
    logic signed [DB_W-1:0]   cfg_floor;
    logic signed [DB_W-1:0]   cfg_ceiling;
    logic signed [DB_W-1:0]   cfg_warn;
    logic                     cfg_reverse;
    logic [LEN_W-1:0]         cfg_bar;
    logic [DEFL_W-1:0]        held_defl;

    meter_t   meter_expect_q[$];
    dir_row_t dir_rows[$];

    int requests_sent  = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    iec_level_bar_meter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .opcode       (opcode),
        .level_db     (level_db),
        .meter_valid  (meter_valid),
        .meter_stall  (meter_stall),
        .green_end    (green_end),
        .amber_end    (amber_end),
        .red_end      (red_end),
        .peak_pos     (peak_pos),
        .peak_shown   (peak_shown),
        .deflection   (deflection)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Seven-piece scale, 1/16 dB in, 1/64 percent out. Each piece is written
    // as its start point plus slope; note the step up at -60 dB.
    function automatic int meter_scale(input logic signed [DB_W-1:0] lvl);
        int d;
        d = int'(lvl);
        if (d >= -320) return 3200 + (d + 320) * 10;
        if (d >= -480) return 1920 + (d + 480) * 8;
        if (d >= -640) return 960 + (d + 640) * 6;
        if (d >= -800) return 480 + (d + 800) * 3;
        if (d >= -960) return 320 + (d + 960) * 2;
        if (d >= -1120) return d + 1120;
        return 0;
    endfunction

    // Segment length trunc(n * len / den), zero for n <= 0, capped at len.
    function automatic int bar_span(input int n, input int den, input int len);
        longint q;
        if (n <= 0 || den <= 0) return 0;
        q = (longint'(n) * longint'(len)) / longint'(den);
        return (q > longint'(len)) ? len : int'(q);
    endfunction

    // Work out the result of one accepted request and advance the held peak.
    function automatic meter_t predict_meter(input logic clr,
                                             input logic signed [DB_W-1:0] lvl);
        meter_t m;
        int     v;
        int     lo;
        int     up;
        int     den;
        int     nv;
        int     na;
        int     len;
        m = '0;
        if (clr) begin
            held_defl = '0;
            return m;
        end
        v  = meter_scale(lvl);
        lo = meter_scale(cfg_floor);
        up = meter_scale(cfg_ceiling);
        // The peak follows a louder sample but is clamped to the ceiling,
        // which can pull down a peak held under an earlier, higher ceiling.
        if (v > int'(held_defl))
            held_defl = DEFL_W'((v > up) ? up : v);
        len = int'(cfg_bar);
        if (len > BAR_MAX) len = BAR_MAX;
        den = up - lo;
        if (den > 0) begin
            nv = v - lo;
            na = meter_scale(cfg_warn) - lo;
            if (cfg_reverse) na = den - na;
            if (nv < na) begin
                m.green = LEN_W'(bar_span(nv, den, len));
                m.amber = m.green;
                m.red   = m.green;
            end
            else begin
                m.green = LEN_W'(bar_span(na, den, len));
                m.red   = LEN_W'(bar_span(nv, den, len));
                m.amber = (v <= int'(FULL_SCALE)) ? m.red :
                          LEN_W'(bar_span(int'(FULL_SCALE) - lo, den, len));
            end
            if (int'(held_defl) - lo > 0) begin
                m.shown = 1'b1;
                m.peak  = LEN_W'(bar_span(int'(held_defl) - lo, den, len));
            end
        end
        m.defl = DEFL_W'(v);
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("meter mismatch: %s", what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            note_mismatch($sformatf("result %0d %s expected %0d got %0d",
                                    results_seen, name, want, got));
    endtask

    // Compare every accepted result with the oldest pending prediction.
    always @(posedge clk) begin : meter_monitor
        meter_t seen;
        meter_t want;
        if (rst_n && meter_valid && !meter_stall) begin
            seen = {green_end, amber_end, red_end, peak_pos, peak_shown, deflection};
            if (meter_expect_q.size() == 0) begin
                note_mismatch($sformatf("result %0d arrived with none pending",
                                        results_seen));
            end
            else begin
                want = meter_expect_q.pop_front();
                check_field("green_end",  seen.green, want.green);
                check_field("amber_end",  seen.amber, want.amber);
                check_field("red_end",    seen.red,   want.red);
                check_field("peak_pos",   seen.peak,  want.peak);
                check_field("peak_shown", seen.shown, want.shown);
                check_field("deflection", seen.defl,  want.defl);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: drop stall in and out at the falling edge
    // ------------------------------------------------------------------------
    initial begin : meter_sink
        meter_stall = 1'b0;
        forever begin
            @(negedge clk);
            meter_stall <= (recv_idle_pct > 0) &&
                           (int'($urandom_range(99)) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------

    // One write, setup then access. Enter and leave at a falling edge; psel
    // stays up so that writes run back to back.
    task automatic apb_write(input logic [2:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
    endtask

    // Write all five registers and track them for the prediction.
    task automatic set_meter_config(input int fl, input int ce, input int wa,
                                    input int rev, input int bar);
        apb_write(REG_FLOOR,   fl);
        apb_write(REG_CEILING, ce);
        apb_write(REG_WARN,    wa);
        apb_write(REG_REVERSE, rev);
        apb_write(REG_BAR,     bar);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_floor   = DB_W'(fl);
        cfg_ceiling = DB_W'(ce);
        cfg_warn    = DB_W'(wa);
        cfg_reverse = 1'(rev);
        cfg_bar     = LEN_W'(bar);
    endtask

    // ------------------------------------------------------------------------
    // Sample channel
    // ------------------------------------------------------------------------

    // Offer one request and hold it until accepted. Enter and leave at a
    // falling edge. A typed row queues its hand-worked result, but the
    // prediction still runs so that the held peak stays in step.
    task automatic offer_request(input logic clr, input logic signed [DB_W-1:0] lvl,
                                 input logic typed, input meter_t want);
        meter_t predicted;
        // Sender idles 23 / receiver 65 percent, then the other way round,
        // then nobody idles for the last third.
        if (requests_sent < 450) begin
            send_idle_pct = 23;
            recv_idle_pct = 65;
        end
        else if (requests_sent < 900) begin
            send_idle_pct = 65;
            recv_idle_pct = 23;
        end
        else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (send_idle_pct > 0 && int'($urandom_range(99)) < send_idle_pct) begin
            // Drop valid and scramble the payload; the block must ignore it.
            sample_valid <= 1'b0;
            opcode       <= 1'($urandom);
            level_db     <= DB_W'($urandom);
            @(negedge clk);
            while (int'($urandom_range(99)) < send_idle_pct) @(negedge clk);
        end
        sample_valid <= 1'b1;
        opcode       <= clr;
        level_db     <= lvl;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        predicted = predict_meter(clr, lvl);
        meter_expect_q.push_back(typed ? want : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    function automatic dir_row_t mk_row(input int clr, input int lvl, input int typed,
                                        input int g, input int a, input int r,
                                        input int p, input int s, input int d);
        dir_row_t row;
        row.clr        = 1'(clr);
        row.lvl        = DB_W'(lvl);
        row.typed      = 1'(typed);
        row.want.green = LEN_W'(g);
        row.want.amber = LEN_W'(a);
        row.want.red   = LEN_W'(r);
        row.want.peak  = LEN_W'(p);
        row.want.shown = 1'(s);
        row.want.defl  = DEFL_W'(d);
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                     phase;
        int                     n;
        int                     pick;
        logic                   clr;
        logic signed [DB_W-1:0] lvl;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sample_valid = 1'b0;
        opcode       = 1'b0;
        level_db     = '0;

        // Reset values of the registers and the held peak.
        cfg_floor   = -12'sd960;
        cfg_ceiling = 12'sd96;
        cfg_warn    = -12'sd96;
        cfg_reverse = 1'b0;
        cfg_bar     = 10'd100;
        held_defl   = '0;

        // Directed table under the reset settings (floor 320, ceiling 7360,
        // amber point 5120 above the floor, bar 100). Typed rows:
        //   lowest level with nothing held    -> all zero
        //   highest level, peak clamps to top -> red and peak at full bar
        //   clear, with and without level bits set -> all zero
        //   0 dB right after a clear          -> exactly full scale
        //        clr  level   typed green amber red peak shown defl
        dir_rows.push_back(mk_row(0, -2048, 1,  0,  0,   0,   0, 0,     0));
        dir_rows.push_back(mk_row(0,  2047, 1, 72, 86, 100, 100, 1, 26870));
        dir_rows.push_back(mk_row(1,     0, 1,  0,  0,   0,   0, 0,     0));
        dir_rows.push_back(mk_row(0,     0, 1, 72, 86,  86,  86, 1,  6400));
        dir_rows.push_back(mk_row(1,    -1, 1,  0,  0,   0,   0, 0,     0));
        // Scale corners either side of each break, warn and ceiling levels.
        dir_rows.push_back(mk_row(0, -1121, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, -1120, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -961, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -960, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -801, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -800, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -641, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -640, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -481, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -480, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -321, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  -320, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,   -96, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,    -1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,     1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,    96, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,    97, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  1000, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, -2047, 0, 0, 0, 0, 0, 0, 0));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            offer_request(dir_rows[i].clr, dir_rows[i].lvl,
                          dir_rows[i].typed, dir_rows[i].want);

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            // Drain every pending result before touching the registers.
            sample_valid <= 1'b0;
            while (meter_expect_q.size() != 0) @(negedge clk);

            //                           floor  ceiling  warn  rev  bar
            case (phase)
                0: set_meter_config(-2048,  2047,     0,  0, 1023);  // widest scale
                1: set_meter_config( 2047, -2048,     0,  1,  500);  // empty scale
                2: set_meter_config( -960,    96,   -96,  1,  100);  // reversed warn
                3: set_meter_config(-1200,     0, -2048,  0,    0);  // zero bar
                4: set_meter_config( -640,  -640,  2047,  0,    1);  // floor equals ceiling
                5: set_meter_config( -800,  -200,  2047,  1,    1);  // amber point below zero
                6: set_meter_config(-1100,  -300,  -500,  0,   37);  // lowered ceiling
                default:
                    set_meter_config(int'($urandom_range(4095)) - 2048,
                                     int'($urandom_range(4095)) - 2048,
                                     int'($urandom_range(4095)) - 2048,
                                     int'($urandom_range(1)),
                                     int'($urandom_range(1023)));
            endcase

            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = int'($urandom_range(19));
                clr  = (pick == 0);
                if (pick < 9)
                    lvl = DB_W'($urandom);                           // any code
                else if (pick < 17)
                    lvl = DB_W'(int'($urandom_range(1420)) - 1120);  // on the scale
                else
                    lvl = DB_W'(-1120 + 160 * int'($urandom_range(5))
                                + int'($urandom_range(2)) - 1);      // near a break
                offer_request(clr, lvl, 1'b0, '0);
            end
        end

        sample_valid <= 1'b0;
        while (meter_expect_q.size() != 0) @(negedge clk);
        // Hold a little longer so that a stray extra result gets caught.
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("PASS iec_level_bar_meter");
        else
            $display("FAIL iec_level_bar_meter");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("FAIL iec_level_bar_meter");
        $finish;
    end

endmodule

>>> iec_level_bar_meter.f
design/ilbm_pkg.sv
design/ilbm_div.sv
design/iec_level_bar_meter.sv
bench/tb_iec_level_bar_meter.sv
